// ----- src/tid_pkg.sv -----
// ----------------------------------------------------------------------------
// tid_pkg
// Shared constants, codes, types and helper functions of the Tomasulo block.
// ----------------------------------------------------------------------------
`default_nettype none

package tid_pkg;

  localparam int ADD_STATIONS  = 6;
  localparam int MUL_STATIONS  = 3;
  localparam int LOAD_STATIONS = 3;
  localparam int NSTAT         = ADD_STATIONS + MUL_STATIONS + LOAD_STATIONS;
  localparam int ADD_UNITS     = 3;
  localparam int MUL_UNITS     = 2;
  localparam int LOAD_UNITS    = 2;
  localparam int MAX_UNITS     = 4;
  localparam int NCLASS        = 3;

  localparam int IDX_W   = $clog2(NSTAT + 1);
  localparam int UNIT_W  = $clog2(MAX_UNITS);
  localparam int NREG    = 32;
  localparam int REG_W   = 5;
  localparam int DATA_W  = 32;
  localparam int SEQ_W   = 16;
  localparam int LAT_W   = 4;
  localparam int CFG_IDX_W = 8;
  localparam int NCFG    = 4;

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_LI  = 3'd0;
  localparam opcode_t OP_ADD = 3'd1;
  localparam opcode_t OP_SUB = 3'd2;
  localparam opcode_t OP_MUL = 3'd3;
  localparam opcode_t OP_DIV = 3'd4;

  typedef logic [1:0] cls_t;
  localparam cls_t CLS_ADD = 2'd0;
  localparam cls_t CLS_MUL = 2'd1;
  localparam cls_t CLS_LD  = 2'd2;

  typedef logic [1:0] event_t;
  localparam event_t EV_ISSUE = 2'd0;
  localparam event_t EV_DONE  = 2'd1;
  localparam event_t EV_WB    = 2'd2;
  localparam event_t EV_EOT   = 2'd3;

  localparam logic [1:0] CFG_ADD_LAT = 2'd0;
  localparam logic [1:0] CFG_MUL_LAT = 2'd1;
  localparam logic [1:0] CFG_LD_LAT  = 2'd2;
  localparam logic [1:0] CFG_DZ_LAT  = 2'd3;

  typedef struct packed {
    logic             ld_in;
    logic             wb_start;
    logic             wb_commit;
    logic             cd_step;
    logic             dp_step;
    logic             rd_src_a;
    logic             rd_src_b;
    logic             iss_commit;
    logic             eot_emit;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic fin;
    logic alu_done;
    logic out_free;
    logic iss_ok;
  } dp_stat_t;

  function automatic cls_t stn_class(logic [IDX_W-1:0] s);
    if (int'(s) < ADD_STATIONS) return CLS_ADD;
    if (int'(s) < ADD_STATIONS + MUL_STATIONS) return CLS_MUL;
    return CLS_LD;
  endfunction

  function automatic cls_t op_class(opcode_t op);
    if (op == OP_LI) return CLS_LD;
    if (op == OP_ADD || op == OP_SUB) return CLS_ADD;
    return CLS_MUL;
  endfunction

  function automatic int units_of(cls_t c);
    if (c == CLS_ADD) return ADD_UNITS;
    if (c == CLS_MUL) return MUL_UNITS;
    return LOAD_UNITS;
  endfunction

  function automatic logic [LAT_W-1:0] lat_eff(logic [LAT_W-1:0] v);
    return (v == '0) ? LAT_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

// ----- src/tid_in_if.sv -----
// ----------------------------------------------------------------------------
// tid_in_if
// Input channel: one machine tick, optionally offering an instruction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tid_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  opcode;
  logic [4:0]  dest_reg;
  logic [4:0]  src_a_reg;
  logic [4:0]  src_b_reg;
  logic signed [31:0] load_value;

  modport source (output valid, cmd, opcode, dest_reg, src_a_reg, src_b_reg, load_value,
                  input ready);
  modport sink (input valid, cmd, opcode, dest_reg, src_a_reg, src_b_reg, load_value,
                output ready);
endinterface

`default_nettype wire

// ----- src/tid_out_if.sv -----
// ----------------------------------------------------------------------------
// tid_out_if
// Result channel: issue, execution-done, writeback and end-of-tick events.
// ----------------------------------------------------------------------------
`default_nettype none

interface tid_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [15:0] seq_tag;
  logic [4:0]  dest_index;
  logic signed [31:0] result_value;
  logic        reg_updated;
  logic        all_idle;
  logic        last;

  modport source (output valid, event_kind, seq_tag, dest_index, result_value, reg_updated,
                  all_idle, last, input ready);
  modport sink (input valid, event_kind, seq_tag, dest_index, result_value, reg_updated,
                all_idle, last, output ready);
endinterface

`default_nettype wire

// ----- src/tid_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tid_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tid_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/tid_alu.sv -----
// ----------------------------------------------------------------------------
// tid_alu
// Shared execution unit: registered add, sub and multiply, iterative divide.
// ----------------------------------------------------------------------------
`default_nettype none

module tid_alu (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire tid_pkg::opcode_t  op,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output logic                   done,
  output logic [31:0]            res
);
  import tid_pkg::*;

  logic        busy_r, busy_nxt;
  logic        fix_r, fix_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] ub_r, ub_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] quick;
  logic [32:0] trial;

  always_comb begin
    case (op)
      OP_ADD:  quick = a + b;
      OP_SUB:  quick = a - b;
      OP_MUL:  quick = a * b;
      default: quick = a;
    endcase
  end

  assign trial = {rem_r, quo_r[31]} - {1'b0, ub_r};

  always_comb begin
    busy_nxt = busy_r;
    fix_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ub_nxt   = ub_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    if (start) begin
      if (op == OP_DIV && b != '0) begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        rem_nxt  = '0;
        quo_nxt  = a[31] ? (32'd0 - a) : a;
        ub_nxt   = b[31] ? (32'd0 - b) : b;
        neg_nxt  = a[31] ^ b[31];
      end else begin
        res_nxt  = quick;
        done_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        fix_nxt  = 1'b1;
      end
    end else if (fix_r) begin
      res_nxt  = neg_r ? (32'd0 - quo_r) : quo_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ub_r  <= ub_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

`default_nettype wire

// ----- src/tid_datapath.sv -----
// ----------------------------------------------------------------------------
// tid_datapath
// Reservation stations, unit busy masks, register file with rename tags,
// execution unit and result register, driven by the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tid_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tid_pkg::dp_cmd_t   cmd,
  output tid_pkg::dp_stat_t       stat,
  input  wire logic               in_cmd,
  input  wire tid_pkg::opcode_t   in_opcode,
  input  wire logic [4:0]         in_dest_reg,
  input  wire logic [4:0]         in_src_a_reg,
  input  wire logic [4:0]         in_src_b_reg,
  input  wire logic [31:0]        in_load_value,
  input  wire logic               cfg_valid,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [3:0]         cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_event_kind,
  output logic [15:0]             out_seq_tag,
  output logic [4:0]              out_dest_index,
  output logic [31:0]             out_result_value,
  output logic                    out_reg_updated,
  output logic                    out_all_idle,
  output logic                    out_last
);
  import tid_pkg::*;

  logic [NSTAT-1:0]  busy_r, busy_nxt;
  logic [NSTAT-1:0]  running_r, running_nxt;
  opcode_t           op_r    [NSTAT];
  opcode_t           op_nxt  [NSTAT];
  logic [SEQ_W-1:0]  seq_r   [NSTAT];
  logic [SEQ_W-1:0]  seq_nxt [NSTAT];
  logic [REG_W-1:0]  dest_r  [NSTAT];
  logic [REG_W-1:0]  dest_nxt[NSTAT];
  logic [DATA_W-1:0] opa_r   [NSTAT];
  logic [DATA_W-1:0] opa_nxt [NSTAT];
  logic [DATA_W-1:0] opb_r   [NSTAT];
  logic [DATA_W-1:0] opb_nxt [NSTAT];
  logic [IDX_W-1:0]  wta_r   [NSTAT];
  logic [IDX_W-1:0]  wta_nxt [NSTAT];
  logic [IDX_W-1:0]  wtb_r   [NSTAT];
  logic [IDX_W-1:0]  wtb_nxt [NSTAT];
  logic [LAT_W-1:0]  timer_r [NSTAT];
  logic [LAT_W-1:0]  timer_nxt[NSTAT];
  logic [UNIT_W-1:0] unit_r  [NSTAT];
  logic [UNIT_W-1:0] unit_nxt[NSTAT];
  logic [MAX_UNITS-1:0] ubusy_r  [NCLASS];
  logic [MAX_UNITS-1:0] ubusy_nxt[NCLASS];
  logic [LAT_W-1:0]  lat_r   [NCFG];
  logic [LAT_W-1:0]  lat_nxt [NCFG];
  logic [SEQ_W-1:0]  next_seq_r, next_seq_nxt;

  logic              in_cmd_r;
  opcode_t           in_op_r;
  logic [REG_W-1:0]  in_dst_r, in_ra_r, in_rb_r;
  logic [DATA_W-1:0] in_lv_r;

  logic [DATA_W-1:0] val_mem [NREG];
  logic [IDX_W-1:0]  own_mem [NREG];
  logic [NREG-1:0]   val_vld_r, own_vld_r;
  logic [DATA_W-1:0] rd_val_r;
  logic [IDX_W-1:0]  rd_own_r;
  logic              rd_vv_r, rd_ov_r;
  logic [DATA_W-1:0] val_eff;
  logic [IDX_W-1:0]  own_eff;
  logic [DATA_W-1:0] cap_val_r;
  logic [IDX_W-1:0]  cap_own_r;

  logic              we_val, we_own, rd_en;
  logic [REG_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0] wd_val;
  logic [IDX_W-1:0]  wd_own;

  logic              alu_start, alu_done;
  logic [DATA_W-1:0] alu_res;

  logic              emit;
  event_t            ev_kind;
  logic [SEQ_W-1:0]  ev_seq;
  logic [REG_W-1:0]  ev_dest;
  logic [DATA_W-1:0] ev_val;
  logic              ev_upd, ev_idle, ev_last;

  logic              out_valid_r, out_valid_nxt;
  event_t            out_kind_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic [REG_W-1:0]  out_dest_r;
  logic [DATA_W-1:0] out_val_r;
  logic              out_upd_r, out_idle_r, out_last_r;

  logic              iss_found, iss_ok;
  logic [IDX_W-1:0]  iss_s;
  cls_t              iss_cls;

  logic              dsp_en, dsp_bz, dsp_found;
  logic [IDX_W-1:0]  dsp_s;
  opcode_t           dsp_op;
  cls_t              dsp_cls;
  logic [LAT_W-1:0]  dsp_lat;

  logic [IDX_W-1:0]  tag;
  cls_t              cur_cls;
  logic              upd;
  logic [REG_W-1:0]  d;

  assign val_eff = rd_vv_r ? rd_val_r : '0;
  assign own_eff = rd_ov_r ? rd_own_r : '0;
  assign tag     = cmd.idx + IDX_W'(1);
  assign cur_cls = stn_class(cmd.idx);

  tid_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (alu_start),
    .op    (op_r[cmd.idx]),
    .a     (opa_r[cmd.idx]),
    .b     (opb_r[cmd.idx]),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_comb begin
    iss_cls   = op_class(in_op_r);
    iss_found = 1'b0;
    iss_s     = '0;
    for (int j = 0; j < NSTAT; j++) begin
      if (!iss_found && stn_class(IDX_W'(j)) == iss_cls && !busy_r[j]) begin
        iss_found = 1'b1;
        iss_s     = IDX_W'(j);
      end
    end
    iss_ok = in_cmd_r && (in_op_r <= OP_DIV) && iss_found;
  end

  always_comb begin
    stat.fin      = busy_r[cmd.idx] && running_r[cmd.idx] && (timer_r[cmd.idx] == '0);
    stat.alu_done = alu_done;
    stat.out_free = !out_valid_r || out_ready;
    stat.iss_ok   = iss_ok;
  end

  always_comb begin
    busy_nxt     = busy_r;
    running_nxt  = running_r;
    op_nxt       = op_r;
    seq_nxt      = seq_r;
    dest_nxt     = dest_r;
    opa_nxt      = opa_r;
    opb_nxt      = opb_r;
    wta_nxt      = wta_r;
    wtb_nxt      = wtb_r;
    timer_nxt    = timer_r;
    unit_nxt     = unit_r;
    ubusy_nxt    = ubusy_r;
    lat_nxt      = lat_r;
    next_seq_nxt = next_seq_r;
    we_val    = 1'b0;
    we_own    = 1'b0;
    wr_addr   = '0;
    wd_val    = '0;
    wd_own    = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    alu_start = 1'b0;
    emit      = 1'b0;
    ev_kind   = EV_ISSUE;
    ev_seq    = '0;
    ev_dest   = '0;
    ev_val    = '0;
    ev_upd    = 1'b0;
    ev_idle   = 1'b0;
    ev_last   = 1'b0;
    dsp_en    = 1'b0;
    dsp_s     = cmd.idx;
    dsp_op    = op_r[cmd.idx];
    dsp_bz    = 1'b0;
    upd       = 1'b0;
    d         = dest_r[cmd.idx];

    if (cfg_valid && int'(cfg_index) < NCFG) begin
      lat_nxt[cfg_index[1:0]] = cfg_data;
    end

    if (cmd.wb_start) begin
      alu_start = 1'b1;
      rd_en     = 1'b1;
      rd_addr   = dest_r[cmd.idx];
    end

    if (cmd.wb_commit) begin
      upd = (own_eff == tag);
      if (upd) begin
        we_val  = 1'b1;
        we_own  = 1'b1;
        wr_addr = d;
        wd_val  = alu_res;
        wd_own  = '0;
      end
      ubusy_nxt[cur_cls][unit_r[cmd.idx]] = 1'b0;
      for (int j = 0; j < NSTAT; j++) begin
        if (wta_r[j] == tag) begin
          wta_nxt[j] = '0;
          opa_nxt[j] = alu_res;
        end
        if (wtb_r[j] == tag) begin
          wtb_nxt[j] = '0;
          opb_nxt[j] = alu_res;
        end
      end
      emit    = 1'b1;
      ev_kind = EV_WB;
      ev_seq  = seq_r[cmd.idx];
      ev_dest = d;
      ev_val  = alu_res;
      ev_upd  = upd;
      busy_nxt[cmd.idx]    = 1'b0;
      running_nxt[cmd.idx] = 1'b0;
      op_nxt[cmd.idx]      = OP_LI;
      opa_nxt[cmd.idx]     = '0;
      opb_nxt[cmd.idx]     = '0;
      timer_nxt[cmd.idx]   = '0;
    end

    if (cmd.cd_step) begin
      if (busy_r[cmd.idx] && running_r[cmd.idx] && timer_r[cmd.idx] != '0) begin
        timer_nxt[cmd.idx] = timer_r[cmd.idx] - LAT_W'(1);
        if (timer_r[cmd.idx] == LAT_W'(1)) begin
          emit    = 1'b1;
          ev_kind = EV_DONE;
          ev_seq  = seq_r[cmd.idx];
          ev_dest = dest_r[cmd.idx];
        end
      end
    end

    if (cmd.dp_step) begin
      if (busy_r[cmd.idx] && !running_r[cmd.idx] && wta_r[cmd.idx] == '0 &&
          wtb_r[cmd.idx] == '0) begin
        dsp_en = 1'b1;
        dsp_bz = (opb_r[cmd.idx] == '0);
      end
    end

    if (cmd.rd_src_a) begin
      rd_en   = 1'b1;
      rd_addr = in_ra_r;
    end

    if (cmd.rd_src_b) begin
      rd_en   = 1'b1;
      rd_addr = in_rb_r;
    end

    if (cmd.iss_commit) begin
      busy_nxt[iss_s]    = 1'b1;
      running_nxt[iss_s] = 1'b0;
      timer_nxt[iss_s]   = '0;
      op_nxt[iss_s]      = in_op_r;
      seq_nxt[iss_s]     = next_seq_r;
      dest_nxt[iss_s]    = in_dst_r;
      if (in_op_r == OP_LI) begin
        opa_nxt[iss_s] = in_lv_r;
        opb_nxt[iss_s] = '0;
        wta_nxt[iss_s] = '0;
        wtb_nxt[iss_s] = '0;
      end else begin
        opa_nxt[iss_s] = (cap_own_r == '0) ? cap_val_r : '0;
        wta_nxt[iss_s] = cap_own_r;
        opb_nxt[iss_s] = (own_eff == '0) ? val_eff : '0;
        wtb_nxt[iss_s] = own_eff;
      end
      we_own  = 1'b1;
      wr_addr = in_dst_r;
      wd_own  = iss_s + IDX_W'(1);
      dsp_en  = (wta_nxt[iss_s] == '0) && (wtb_nxt[iss_s] == '0);
      dsp_s   = iss_s;
      dsp_op  = in_op_r;
      dsp_bz  = (opb_nxt[iss_s] == '0);
      emit    = 1'b1;
      ev_kind = EV_ISSUE;
      ev_seq  = next_seq_r;
      ev_dest = in_dst_r;
      next_seq_nxt = next_seq_r + SEQ_W'(1);
    end

    if (cmd.eot_emit) begin
      emit    = 1'b1;
      ev_kind = EV_EOT;
      ev_idle = (busy_r == '0);
      ev_last = 1'b1;
    end

    dsp_cls   = stn_class(dsp_s);
    dsp_found = 1'b0;
    case (dsp_cls)
      CLS_ADD: dsp_lat = lat_eff(lat_r[CFG_ADD_LAT]);
      CLS_MUL: dsp_lat = (dsp_op == OP_DIV && dsp_bz) ? lat_eff(lat_r[CFG_DZ_LAT])
                                                       : lat_eff(lat_r[CFG_MUL_LAT]);
      default: dsp_lat = lat_eff(lat_r[CFG_LD_LAT]);
    endcase
    if (dsp_en) begin
      for (int j = 0; j < MAX_UNITS; j++) begin
        if (!dsp_found && j < units_of(dsp_cls) && !ubusy_nxt[dsp_cls][j]) begin
          dsp_found = 1'b1;
          ubusy_nxt[dsp_cls][j] = 1'b1;
          unit_nxt[dsp_s]       = UNIT_W'(j);
          running_nxt[dsp_s]    = 1'b1;
          timer_nxt[dsp_s]      = dsp_lat;
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      running_r   <= '0;
      next_seq_r  <= '0;
      out_valid_r <= 1'b0;
      val_vld_r   <= '0;
      own_vld_r   <= '0;
      rd_vv_r     <= 1'b0;
      rd_ov_r     <= 1'b0;
      for (int c = 0; c < NCLASS; c++) begin
        ubusy_r[c] <= '0;
      end
      lat_r[CFG_ADD_LAT] <= LAT_W'(3);
      lat_r[CFG_MUL_LAT] <= LAT_W'(4);
      lat_r[CFG_LD_LAT]  <= LAT_W'(3);
      lat_r[CFG_DZ_LAT]  <= LAT_W'(1);
      for (int j = 0; j < NSTAT; j++) begin
        wta_r[j] <= '0;
        wtb_r[j] <= '0;
      end
    end else begin
      busy_r      <= busy_nxt;
      running_r   <= running_nxt;
      next_seq_r  <= next_seq_nxt;
      out_valid_r <= out_valid_nxt;
      ubusy_r     <= ubusy_nxt;
      lat_r       <= lat_nxt;
      wta_r       <= wta_nxt;
      wtb_r       <= wtb_nxt;
      if (we_val) begin
        val_vld_r[wr_addr] <= 1'b1;
      end
      if (we_own) begin
        own_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vv_r <= val_vld_r[rd_addr];
        rd_ov_r <= own_vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    seq_r   <= seq_nxt;
    dest_r  <= dest_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    timer_r <= timer_nxt;
    unit_r  <= unit_nxt;
    if (cmd.ld_in) begin
      in_cmd_r <= in_cmd;
      in_op_r  <= in_opcode;
      in_dst_r <= in_dest_reg;
      in_ra_r  <= in_src_a_reg;
      in_rb_r  <= in_src_b_reg;
      in_lv_r  <= in_load_value;
    end
    if (cmd.rd_src_b) begin
      cap_val_r <= val_eff;
      cap_own_r <= own_eff;
    end
    if (emit) begin
      out_kind_r <= ev_kind;
      out_seq_r  <= ev_seq;
      out_dest_r <= ev_dest;
      out_val_r  <= ev_val;
      out_upd_r  <= ev_upd;
      out_idle_r <= ev_idle;
      out_last_r <= ev_last;
    end
  end

  always_ff @(posedge clk) begin
    if (we_val) begin
      val_mem[wr_addr] <= wd_val;
    end
    if (we_own) begin
      own_mem[wr_addr] <= wd_own;
    end
    if (rd_en) begin
      rd_val_r <= val_mem[rd_addr];
      rd_own_r <= own_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_seq_tag      = out_seq_r;
  assign out_dest_index   = out_dest_r;
  assign out_result_value = out_val_r;
  assign out_reg_updated  = out_upd_r;
  assign out_all_idle     = out_idle_r;
  assign out_last         = out_last_r;

  a_issue_has_station: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iss_commit |-> iss_ok)
    else $error("issue committed without a free station");

  a_wb_only_finished: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb_commit |-> stat.fin)
    else $error("writeback of a station that has not finished");

  a_wb_frees_station: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb_commit |=> !busy_r[$past(cmd.idx)])
    else $error("station still busy after writeback");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- src/tid_ctrl.sv -----
// ----------------------------------------------------------------------------
// tid_ctrl
// Tick sequencer: walks the stations through writeback, countdown, dispatch,
// then issue and the end-of-tick report.
// ----------------------------------------------------------------------------
`default_nettype none

module tid_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tid_pkg::dp_stat_t stat,
  output tid_pkg::dp_cmd_t       cmd
);
  import tid_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WB_CHK  = 4'd1;
  localparam logic [3:0] S_WB_WAIT = 4'd2;
  localparam logic [3:0] S_WB_PUT  = 4'd3;
  localparam logic [3:0] S_CD      = 4'd4;
  localparam logic [3:0] S_DP      = 4'd5;
  localparam logic [3:0] S_IS_A    = 4'd6;
  localparam logic [3:0] S_IS_B    = 4'd7;
  localparam logic [3:0] S_IS_C    = 4'd8;
  localparam logic [3:0] S_EOT     = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             at_last;

  assign at_last = (idx_r == IDX_W'(NSTAT - 1));

  always_comb begin
    cmd       = '0;
    cmd.idx   = idx_r;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_WB_CHK;
        end
      end
      S_WB_CHK: begin
        if (stat.fin) begin
          cmd.wb_start = 1'b1;
          state_nxt    = S_WB_WAIT;
        end else if (at_last) begin
          idx_nxt   = '0;
          state_nxt = S_CD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_WB_WAIT: begin
        if (stat.alu_done) begin
          state_nxt = S_WB_PUT;
        end
      end
      S_WB_PUT: begin
        if (stat.out_free) begin
          cmd.wb_commit = 1'b1;
          if (at_last) begin
            idx_nxt   = '0;
            state_nxt = S_CD;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_WB_CHK;
          end
        end
      end
      S_CD: begin
        if (stat.out_free) begin
          cmd.cd_step = 1'b1;
          if (at_last) begin
            idx_nxt   = '0;
            state_nxt = S_DP;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      S_DP: begin
        cmd.dp_step = 1'b1;
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = S_IS_A;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_IS_A: begin
        if (stat.iss_ok) begin
          cmd.rd_src_a = 1'b1;
          state_nxt    = S_IS_B;
        end else begin
          state_nxt = S_EOT;
        end
      end
      S_IS_B: begin
        cmd.rd_src_b = 1'b1;
        state_nxt    = S_IS_C;
      end
      S_IS_C: begin
        if (stat.out_free) begin
          cmd.iss_commit = 1'b1;
          state_nxt      = S_EOT;
        end
      end
      S_EOT: begin
        if (stat.out_free) begin
          cmd.eot_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/tomasulo_issue_dispatch_writeback.sv -----
// ----------------------------------------------------------------------------
// tomasulo_issue_dispatch_writeback
// Tomasulo machine with 12 reservation stations, rename tags and unit pools.
//
// Each transaction on in_chan is one machine tick, which may offer an
// instruction for issue. The tick produces its events on out_chan in order:
// writebacks, execution-done events, the issue event, then an end-of-tick
// event with last set. in_chan is taken again only after that final event
// has been placed in the output register.
// Unless held by a writeback or a stall, the sequencer scans one station per
// cycle in each of the writeback, countdown and dispatch scans, then handles
// issue and end of tick. A writeback waits for the shared execution unit,
// whose divide is iterative. Stalls on out_chan hold the sequencer until the
// output register is free. cfg_chan writes a latency register and is
// always ready. After reset all stations and units are free, the register
// file reads zero with no renames, and the latencies are 3, 4, 3 and 1.
// ----------------------------------------------------------------------------
`default_nettype none

module tomasulo_issue_dispatch_writeback (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tid_in_if.sink      in_chan,
  tid_out_if.source   out_chan,
  tid_cfg_if.sink     cfg_chan
);
  import tid_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] result_value;

  assign cfg_chan.ready = 1'b1;

  tid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tid_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_cmd           (in_chan.cmd),
    .in_opcode        (in_chan.opcode),
    .in_dest_reg      (in_chan.dest_reg),
    .in_src_a_reg     (in_chan.src_a_reg),
    .in_src_b_reg     (in_chan.src_b_reg),
    .in_load_value    ($unsigned(in_chan.load_value)),
    .cfg_valid        (cfg_chan.valid),
    .cfg_index        (cfg_chan.index),
    .cfg_data         (cfg_chan.data),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_event_kind   (out_chan.event_kind),
    .out_seq_tag      (out_chan.seq_tag),
    .out_dest_index   (out_chan.dest_index),
    .out_result_value (result_value),
    .out_reg_updated  (out_chan.reg_updated),
    .out_all_idle     (out_chan.all_idle),
    .out_last         (out_chan.last)
  );

  assign out_chan.result_value = $signed(result_value);

endmodule

`default_nettype wire

// ----- verif/tomasulo_issue_dispatch_writeback_test.sv -----
// ----------------------------------------------------------------------------
// tomasulo_issue_dispatch_writeback_test
// Self-checking testbench for the Tomasulo issue, dispatch and writeback block.
// A driver sends machine ticks from a queue. On each accepted tick, a
// predictor of the stations, rename tags and units computes the expected
// events. A monitor compares each result transaction with the oldest expected
// event. Latency settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tomasulo_issue_dispatch_writeback_test;
  import tid_pkg::*;

  typedef struct {
    logic        cmd;
    logic [2:0]  opcode;
    logic [4:0]  dest;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic [31:0] imm;
  } tick_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [4:0]  dest;
    logic [31:0] value;
    logic        updated;
    logic        idle;
    logic        last;
  } event_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tid_in_if  in_if ();
  tid_out_if out_if ();
  tid_cfg_if cfg_if ();

  tomasulo_issue_dispatch_writeback dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tick_t      tick_q[$];
  event_rec_t pending_events[$];
  bit         failed = 1'b0;
  bit         calm = 1'b0;
  bit         in_taken = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;

  logic        rs_busy [NSTAT];
  logic        rs_run  [NSTAT];
  logic [2:0]  rs_op   [NSTAT];
  logic [15:0] rs_seq  [NSTAT];
  logic [4:0]  rs_dest [NSTAT];
  logic [31:0] rs_a    [NSTAT];
  logic [31:0] rs_b    [NSTAT];
  logic [3:0]  rs_wa   [NSTAT];
  logic [3:0]  rs_wb   [NSTAT];
  logic [4:0]  rs_tmr  [NSTAT];
  int          rs_unit [NSTAT];
  logic [31:0] rf_val  [NREG];
  logic [3:0]  rf_own  [NREG];
  logic [3:0]  unit_mask [NCLASS];
  logic [15:0] seq_ctr;
  logic [3:0]  lat_reg [NCFG];

  function automatic int class_of(int s);
    if (s < ADD_STATIONS) return 0;
    if (s < ADD_STATIONS + MUL_STATIONS) return 1;
    return 2;
  endfunction

  function automatic logic [31:0] alu_result(int s);
    logic [31:0] a, b, ua, ub, q;
    a = rs_a[s];
    b = rs_b[s];
    case (rs_op[s])
      OP_ADD: return a + b;
      OP_SUB: return a - b;
      OP_MUL: return a * b;
      OP_DIV: begin
        if (b == 32'd0) return a;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
      end
      default: return a;
    endcase
  endfunction

  function automatic logic [4:0] eff_lat(int k);
    return (lat_reg[k] == 4'd0) ? 5'd1 : {1'b0, lat_reg[k]};
  endfunction

  task automatic grab_unit(int s);
    int c, n;
    logic [4:0] t;
    c = class_of(s);
    n = (c == 0) ? ADD_UNITS : (c == 1) ? MUL_UNITS : LOAD_UNITS;
    if (c == 0) t = eff_lat(CFG_ADD_LAT);
    else if (c == 1) t = (rs_op[s] == OP_DIV && rs_b[s] == 32'd0) ? eff_lat(CFG_DZ_LAT)
                                                                   : eff_lat(CFG_MUL_LAT);
    else t = eff_lat(CFG_LD_LAT);
    for (int j = 0; j < n; j++) begin
      if (!unit_mask[c][j]) begin
        unit_mask[c][j] = 1'b1;
        rs_unit[s] = j;
        rs_run[s] = 1'b1;
        rs_tmr[s] = t;
        return;
      end
    end
  endtask

  task automatic push_event(logic [1:0] k, logic [15:0] sq, logic [4:0] d, logic [31:0] v,
                            logic u, logic i, logic l);
    event_rec_t e;
    e.kind = k; e.seq = sq; e.dest = d; e.value = v; e.updated = u; e.idle = i; e.last = l;
    pending_events.insert(pending_events.size(), e);
  endtask

  task automatic machine_reset();
    for (int s = 0; s < NSTAT; s++) begin
      rs_busy[s] = 0; rs_run[s] = 0; rs_op[s] = 0; rs_seq[s] = 0; rs_dest[s] = 0;
      rs_a[s] = 0; rs_b[s] = 0; rs_wa[s] = 0; rs_wb[s] = 0; rs_tmr[s] = 0; rs_unit[s] = 0;
    end
    for (int r = 0; r < NREG; r++) begin
      rf_val[r] = 0;
      rf_own[r] = 0;
    end
    for (int c = 0; c < NCLASS; c++) unit_mask[c] = 0;
    seq_ctr = 0;
    lat_reg[CFG_ADD_LAT] = 4'd3;
    lat_reg[CFG_MUL_LAT] = 4'd4;
    lat_reg[CFG_LD_LAT]  = 4'd3;
    lat_reg[CFG_DZ_LAT]  = 4'd1;
  endtask

  task automatic predict_tick(tick_t t);
    logic [31:0] r;
    logic [3:0] tag;
    logic [4:0] d;
    logic u, idle;
    int lo, hi, c;
    for (int s = 0; s < NSTAT; s++) begin
      if (!rs_busy[s] || !rs_run[s] || rs_tmr[s] != 0) continue;
      r = alu_result(s);
      tag = 4'(s + 1);
      d = rs_dest[s];
      u = 1'b0;
      if (rf_own[d] == tag) begin
        rf_val[d] = r;
        rf_own[d] = 0;
        u = 1'b1;
      end
      c = class_of(s);
      unit_mask[c][rs_unit[s]] = 1'b0;
      for (int j = 0; j < NSTAT; j++) begin
        if (rs_wa[j] == tag) begin rs_wa[j] = 0; rs_a[j] = r; end
        if (rs_wb[j] == tag) begin rs_wb[j] = 0; rs_b[j] = r; end
      end
      push_event(EV_WB, rs_seq[s], d, r, u, 1'b0, 1'b0);
      rs_busy[s] = 0; rs_run[s] = 0; rs_op[s] = 0; rs_a[s] = 0; rs_b[s] = 0; rs_tmr[s] = 0;
    end
    for (int s = 0; s < NSTAT; s++) begin
      if (rs_busy[s] && rs_run[s] && rs_tmr[s] > 0) begin
        rs_tmr[s] = rs_tmr[s] - 1;
        if (rs_tmr[s] == 0) push_event(EV_DONE, rs_seq[s], rs_dest[s], 0, 0, 0, 0);
      end
    end
    for (int s = 0; s < NSTAT; s++)
      if (rs_busy[s] && !rs_run[s] && rs_wa[s] == 0 && rs_wb[s] == 0) grab_unit(s);
    if (t.cmd && t.opcode <= OP_DIV) begin
      if (t.opcode == OP_LI) begin lo = ADD_STATIONS + MUL_STATIONS; hi = NSTAT; end
      else if (t.opcode <= OP_SUB) begin lo = 0; hi = ADD_STATIONS; end
      else begin lo = ADD_STATIONS; hi = ADD_STATIONS + MUL_STATIONS; end
      for (int s = lo; s < hi; s++) begin
        if (rs_busy[s]) continue;
        rs_busy[s] = 1; rs_run[s] = 0; rs_tmr[s] = 0;
        rs_op[s] = t.opcode; rs_seq[s] = seq_ctr; rs_dest[s] = t.dest;
        rs_wa[s] = 0; rs_wb[s] = 0;
        if (t.opcode == OP_LI) begin
          rs_a[s] = t.imm;
          rs_b[s] = 0;
        end else begin
          if (rf_own[t.src_a] == 0) rs_a[s] = rf_val[t.src_a];
          else begin rs_a[s] = 0; rs_wa[s] = rf_own[t.src_a]; end
          if (rf_own[t.src_b] == 0) rs_b[s] = rf_val[t.src_b];
          else begin rs_b[s] = 0; rs_wb[s] = rf_own[t.src_b]; end
        end
        rf_own[t.dest] = 4'(s + 1);
        if (rs_wa[s] == 0 && rs_wb[s] == 0) grab_unit(s);
        push_event(EV_ISSUE, seq_ctr, t.dest, 0, 0, 0, 0);
        seq_ctr = seq_ctr + 1;
        break;
      end
    end
    idle = 1'b1;
    for (int s = 0; s < NSTAT; s++) if (rs_busy[s]) idle = 1'b0;
    push_event(EV_EOT, 0, 0, 0, 0, idle, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) predict_tick(tick_q.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_if.valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        in_if.valid      <= 1'b1;
        in_if.cmd        <= tick_q[0].cmd;
        in_if.opcode     <= tick_q[0].opcode;
        in_if.dest_reg   <= tick_q[0].dest;
        in_if.src_a_reg  <= tick_q[0].src_a;
        in_if.src_b_reg  <= tick_q[0].src_b;
        in_if.load_value <= tick_q[0].imm;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (calm) begin
      out_if.ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 2);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    event_rec_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event kind=%0d seq=%0d dest=%0d value=%h", $realtime,
                 out_if.event_kind, out_if.seq_tag, out_if.dest_index, out_if.result_value);
        failed = 1'b1;
      end else begin
        e = pending_events.pop_front();
        if (out_if.event_kind !== e.kind || out_if.seq_tag !== e.seq ||
            out_if.dest_index !== e.dest || out_if.result_value !== e.value ||
            out_if.reg_updated !== e.updated || out_if.all_idle !== e.idle ||
            out_if.last !== e.last) begin
          $display("%0t: mismatch expected kind=%0d seq=%0d dest=%0d value=%h upd=%b idle=%b last=%b",
                   $realtime, e.kind, e.seq, e.dest, e.value, e.updated, e.idle, e.last);
          $display("%0t:          actual   kind=%0d seq=%0d dest=%0d value=%h upd=%b idle=%b last=%b",
                   $realtime, out_if.event_kind, out_if.seq_tag, out_if.dest_index,
                   out_if.result_value, out_if.reg_updated, out_if.all_idle, out_if.last);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic add_tick(logic c, logic [2:0] op, logic [4:0] d, logic [4:0] a, logic [4:0] b,
                          logic [31:0] v);
    tick_t t;
    t.cmd = c; t.opcode = op; t.dest = d; t.src_a = a; t.src_b = b; t.imm = v;
    tick_q.insert(tick_q.size(), t);
  endtask

  task automatic drain();
    while (tick_q.size() > 0 || in_if.valid || pending_events.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_latency(logic [7:0] idx, logic [3:0] v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx < NCFG) lat_reg[idx] = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_latencies(logic [3:0] a, logic [3:0] m, logic [3:0] l, logic [3:0] z);
    write_latency(CFG_ADD_LAT, a);
    write_latency(CFG_MUL_LAT, m);
    write_latency(CFG_LD_LAT, l);
    write_latency(CFG_DZ_LAT, z);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return 32'($urandom_range(0, 9));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 6));
  endfunction

  task automatic random_ticks(int n);
    int count, r;
    count = 0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_tick(1'b0, 3'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), $urandom);
        count++;
      end else if (r < 11) begin
        add_tick(1'b1, 3'($urandom_range(5, 7)), pick_reg(), pick_reg(), pick_reg(), $urandom);
      end else begin
        if (r < 40) add_tick(1'b1, OP_LI, pick_reg(), 5'($urandom), 5'($urandom), pick_value());
        else add_tick(1'b1, 3'($urandom_range(1, 4)), pick_reg(), pick_reg(), pick_reg(),
                      $urandom);
        count++;
      end
    end
  endtask

  initial begin
    in_if.valid = 0; in_if.cmd = 0; in_if.opcode = 0; in_if.dest_reg = 0;
    in_if.src_a_reg = 0; in_if.src_b_reg = 0; in_if.load_value = 0;
    out_if.ready = 0;
    cfg_if.valid = 0; cfg_if.index = 0; cfg_if.data = 0;
    machine_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_tick(1'b1, OP_LI, 5'd1, 5'd0, 5'd0, 32'h7fff_ffff);
    add_tick(1'b1, OP_LI, 5'd2, 5'd31, 5'd31, 32'd1);
    add_tick(1'b1, OP_LI, 5'd4, 5'd0, 5'd0, 32'h8000_0000);
    add_tick(1'b1, OP_LI, 5'd5, 5'd0, 5'd0, 32'hffff_ffff);
    add_tick(1'b1, OP_ADD, 5'd3, 5'd1, 5'd2, 32'd0);
    add_tick(1'b1, OP_SUB, 5'd6, 5'd4, 5'd2, 32'd0);
    add_tick(1'b1, OP_MUL, 5'd7, 5'd1, 5'd1, 32'd0);
    add_tick(1'b1, OP_DIV, 5'd8, 5'd4, 5'd5, 32'd0);
    add_tick(1'b1, OP_DIV, 5'd9, 5'd1, 5'd0, 32'd0);
    add_tick(1'b1, OP_DIV, 5'd10, 5'd6, 5'd2, 32'd0);
    add_tick(1'b1, OP_ADD, 5'd1, 5'd1, 5'd1, 32'd0);
    for (int i = 0; i < 7; i++) add_tick(1'b1, OP_ADD, 5'(20 + i), 5'd3, 5'd1, 32'd0);
    for (int i = 0; i < 4; i++) add_tick(1'b1, OP_MUL, 5'd31, 5'd8, 5'd31, 32'd0);
    add_tick(1'b1, 3'd7, 5'd31, 5'd31, 5'd31, 32'hffff_ffff);
    for (int i = 0; i < 3; i++) add_tick(1'b0, OP_LI, 5'd0, 5'd0, 5'd0, 32'd0);
    drain();

    set_latencies(4'd1, 4'd1, 4'd1, 4'd1);
    random_ticks(90);
    drain();
    set_latencies(4'd15, 4'd15, 4'd15, 4'd15);
    random_ticks(50);
    drain();
    set_latencies(4'd0, 4'd0, 4'd0, 4'd0);
    write_latency(8'hff, 4'd9);
    random_ticks(80);
    drain();
    set_latencies(4'd2, 4'd7, 4'd5, 4'd12);
    random_ticks(70);
    while (tick_q.size() > 0) @(posedge clk);
    calm = 1'b1;
    random_ticks(60);
    drain();

    if (!failed) begin
      $display("tomasulo_issue_dispatch_writeback test passed");
    end else begin
      $display("tomasulo_issue_dispatch_writeback test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tomasulo_issue_dispatch_writeback test failed");
    $finish;
  end

endmodule
